[rtl/core/tct6_pkg.sv]
// tct6_pkg: shared constants, types and the coefficient function of the
// six-band tasseled-cap transform. Depends on nothing.
package tct6_pkg;

   localparam int NUM_BANDS        = 6;
   localparam int TC_ROWS          = 6;
   localparam int TC_BAND_W        = 16;
   localparam int TC_SEL_W         = 3;
   localparam int TC_VALUE_W       = 34;
   localparam int TC_CSR_W         = 3;
   localparam int TC_CSR_IDX_W     = 3;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam logic [TC_CSR_IDX_W-1:0] CSR_COUNT       = 3'd0;
   localparam logic [TC_CSR_IDX_W-1:0] CSR_SELECT_BASE = 3'd1;
   localparam logic [TC_CSR_IDX_W-1:0] CSR_SELECT_LAST = 3'd6;

   localparam logic [TC_SEL_W-1:0] ROW_MAX   = 3'd5;
   localparam logic [TC_SEL_W-1:0] COUNT_MAX = 3'd6;

   // coefficients in units of 1e-4
   localparam int TC_COEF_E4 [TC_ROWS][NUM_BANDS] = '{
      '{ 3037,  2793,  4743,  5585,  5082,  1863},
      '{-2848, -2435, -5436,  7243,   840, -1800},
      '{ 1509,  1973,  3279,  3406, -7112, -4572},
      '{ 8832,  -819, -4580,   -32,  -563,   130},
      '{  573,  -260,   335, -1943,  4766, -8545},
      '{ 1238, -9038,  4041,   573,  -261,   240}
   };

   typedef struct packed {
      logic [TC_SEL_W-1:0] row;
      logic                last;
      logic                fin;
   } tct6_tag_type;

   // rounds to nearest, ties away from zero; used on constants only
   function automatic int tc_coef(input int row, input int band, input int frac_bits);
      longint c;
      longint mag;
      longint q;
      c   = longint'(TC_COEF_E4[row][band]);
      mag = (c < 0) ? -c : c;
      q   = ((mag << frac_bits) + 64'sd5000) / 64'sd10000;
      return (c < 0) ? int'(-q) : int'(q);
   endfunction

endpackage

[rtl/core/tct6_dot.sv]
// tct6_dot: pipelined dot product of one pixel with one coefficient row,
// with saturation to the result width. Depends on tct6_pkg.
module tct6_dot import tct6_pkg::*; #(
   parameter int SAMPLE_W       = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [SAMPLE_W-1:0]           in_sample [NUM_BANDS],
   input  tct6_tag_type                  in_tag,
   output logic                          out_valid,
   output logic signed [TC_VALUE_W-1:0]  out_value,
   output tct6_tag_type                  out_tag
);

   localparam int COEF_W = COEF_FRAC_BITS + 1;
   localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int ACC_W  = PROD_W + 3;
   localparam int EXT_W  = (ACC_W > TC_VALUE_W) ? ACC_W : TC_VALUE_W;

   logic signed [COEF_W-1:0] coef_rom [TC_ROWS][NUM_BANDS];

   for (genvar r = 0; r < TC_ROWS; r++) begin : g_row
      for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
         assign coef_rom[r][b] = COEF_W'(tc_coef(r, b, COEF_FRAC_BITS));
      end
   end

   // stage 1: operands and coefficient lookup
   logic                     v1_ff;
   tct6_tag_type             tag1_ff;
   logic [SAMPLE_W-1:0]      smp1_ff  [NUM_BANDS];
   logic signed [COEF_W-1:0] coef1_ff [NUM_BANDS];
   // stage 2: products
   logic                     v2_ff;
   tct6_tag_type             tag2_ff;
   logic signed [PROD_W-1:0] prod2_ff [NUM_BANDS];
   logic signed [PROD_W-1:0] prod2_in [NUM_BANDS];
   // stage 3: pair sums
   logic                     v3_ff;
   tct6_tag_type             tag3_ff;
   logic signed [PAIR_W-1:0] pair3_ff [NUM_BANDS/2];
   logic signed [PAIR_W-1:0] pair3_in [NUM_BANDS/2];
   // stage 4: full sum
   logic                     v4_ff;
   tct6_tag_type             tag4_ff;
   logic signed [ACC_W-1:0]  acc4_ff;
   logic signed [ACC_W-1:0]  acc4_in;
   // stage 5: saturated result
   logic                          v5_ff;
   tct6_tag_type                  tag5_ff;
   logic signed [TC_VALUE_W-1:0]  value5_ff;
   logic signed [TC_VALUE_W-1:0]  value5_in;

   logic signed [EXT_W-1:0]          ext;
   logic [EXT_W-TC_VALUE_W:0]        ext_hi;

   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         prod2_in[b] = PROD_W'($signed({1'b0, smp1_ff[b]})) * PROD_W'(coef1_ff[b]);
      end
      for (int p = 0; p < NUM_BANDS/2; p++) begin
         pair3_in[p] = PAIR_W'(prod2_ff[2*p]) + PAIR_W'(prod2_ff[2*p+1]);
      end
      acc4_in = ACC_W'(pair3_ff[0]) + ACC_W'(pair3_ff[1]) + ACC_W'(pair3_ff[2]);
   end

   always_comb begin
      ext    = EXT_W'(acc4_ff);
      ext_hi = ext[EXT_W-1:TC_VALUE_W-1];
      if ((&ext_hi) || (~|ext_hi)) begin
         value5_in = ext[TC_VALUE_W-1:0];
      end else if (ext[EXT_W-1]) begin
         value5_in = {1'b1, {(TC_VALUE_W-1){1'b0}}};
      end else begin
         value5_in = {1'b0, {(TC_VALUE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      for (int b = 0; b < NUM_BANDS; b++) begin
         smp1_ff[b]  <= in_sample[b];
         coef1_ff[b] <= coef_rom[in_tag.row][b];
         prod2_ff[b] <= prod2_in[b];
      end
      tag2_ff <= tag1_ff;
      for (int p = 0; p < NUM_BANDS/2; p++) begin
         pair3_ff[p] <= pair3_in[p];
      end
      tag3_ff   <= tag2_ff;
      acc4_ff   <= acc4_in;
      tag4_ff   <= tag3_ff;
      value5_ff <= value5_in;
      tag5_ff   <= tag4_ff;
   end

   assign out_valid = v5_ff;
   assign out_value = value5_ff;
   assign out_tag   = tag5_ff;

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##5 out_valid)
      else $error("issued component did not reach the output");

   a_tag_chain: assert property (@(posedge clock) disable iff (reset)
      v4_ff |=> (out_tag == $past(tag4_ff)))
      else $error("tag lost alignment with its value");

endmodule

[rtl/core/tasseled_cap_transform_6band_top.sv]
// tasseled_cap_transform_6band_top: control registers, component sequencer
// and the dot-product pipeline. Depends on tct6_pkg and tct6_dot.
//
// Usage: a pixel transfer happens at a rising edge with start high and busy
// low; req_band_a..req_band_f carry the six samples, req_final_pixel marks
// the last pixel of a block. For each of the first component_count selector
// registers (a count of 0 acts as 1, above 6 as 6) the block emits one
// result, in selector order, one per cycle: rsp_strobe is high for exactly
// one cycle per result, with rsp_component, rsp_value (signed,
// COEF_FRAC_BITS fractional bits), rsp_last_component on the final result
// of the pixel and rsp_block_end copied from the pixel. The results of a
// pixel come in consecutive cycles. The sequencer has a single issue slot,
// so a new pixel is taken as the last component of the one before issues;
// busy stays low in that cycle, so pixels follow without a gap. The
// receiver cannot stall; results are never held. Configuration writes via
// csr_we/csr_index/csr_wdata take effect at once; the user must make them
// while the block is idle, which the block does not enforce. Reset clears
// the pipeline and loads count 6 and selectors 0..5.
module tasseled_cap_transform_6band_top import tct6_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [TC_BAND_W-1:0]          req_band_a,
   input  logic [TC_BAND_W-1:0]          req_band_b,
   input  logic [TC_BAND_W-1:0]          req_band_c,
   input  logic [TC_BAND_W-1:0]          req_band_d,
   input  logic [TC_BAND_W-1:0]          req_band_e,
   input  logic [TC_BAND_W-1:0]          req_band_f,
   input  logic                          req_final_pixel,
   output logic                          rsp_strobe,
   output logic [TC_SEL_W-1:0]           rsp_component,
   output logic signed [TC_VALUE_W-1:0]  rsp_value,
   output logic                          rsp_last_component,
   output logic                          rsp_block_end,
   input  logic                          csr_we,
   input  logic [TC_CSR_IDX_W-1:0]       csr_index,
   input  logic [TC_CSR_W-1:0]           csr_wdata
);

   localparam int SAMPLE_W = (SAMPLE_BITS < TC_BAND_W) ? SAMPLE_BITS : TC_BAND_W;

   logic [TC_SEL_W-1:0] count_ff;
   logic [TC_SEL_W-1:0] sel_ff [TC_ROWS];
   logic [TC_SEL_W-1:0] count_eff;

   logic                pix_valid_ff, pix_valid_in;
   logic [TC_SEL_W-1:0] k_ff, k_in;
   logic [SAMPLE_W-1:0] band_ff [NUM_BANDS];
   logic                fin_ff;
   logic [TC_BAND_W-1:0] req_band [NUM_BANDS];

   logic                accept;
   logic                issue_last;
   logic [TC_SEL_W-1:0] issue_row;
   tct6_tag_type        issue_tag;
   tct6_tag_type        out_tag;
   logic [TC_CSR_IDX_W-1:0] sel_idx;

   assign req_band[0] = req_band_a;
   assign req_band[1] = req_band_b;
   assign req_band[2] = req_band_c;
   assign req_band[3] = req_band_d;
   assign req_band[4] = req_band_e;
   assign req_band[5] = req_band_f;

   // control registers
   assign sel_idx = csr_index - CSR_SELECT_BASE;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_MAX;
         for (int r = 0; r < TC_ROWS; r++) begin
            sel_ff[r] <= TC_SEL_W'(r);
         end
      end else if (csr_we) begin
         if (csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata;
         end else if (csr_index >= CSR_SELECT_BASE && csr_index <= CSR_SELECT_LAST) begin
            sel_ff[sel_idx] <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         count_eff = TC_SEL_W'(1);
      end else if (count_ff > COUNT_MAX) begin
         count_eff = COUNT_MAX;
      end else begin
         count_eff = count_ff;
      end
   end

   // sequencer
   assign issue_last = (k_ff == count_eff - TC_SEL_W'(1));
   assign busy       = pix_valid_ff && !issue_last;
   assign accept     = start && !busy;
   assign issue_row  = (sel_ff[k_ff] > ROW_MAX) ? ROW_MAX : sel_ff[k_ff];

   always_comb begin
      issue_tag.row  = issue_row;
      issue_tag.last = issue_last;
      issue_tag.fin  = fin_ff;
   end

   always_comb begin
      pix_valid_in = pix_valid_ff;
      k_in         = k_ff;
      if (accept) begin
         pix_valid_in = 1'b1;
         k_in         = '0;
      end else if (pix_valid_ff) begin
         if (issue_last) begin
            pix_valid_in = 1'b0;
         end else begin
            k_in = k_ff + TC_SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            band_ff[b] <= req_band[b][SAMPLE_W-1:0];
         end
         fin_ff <= req_final_pixel;
      end
   end

   tct6_dot #(
      .SAMPLE_W       (SAMPLE_W),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pix_valid_ff),
      .in_sample (band_ff),
      .in_tag    (issue_tag),
      .out_valid (rsp_strobe),
      .out_value (rsp_value),
      .out_tag   (out_tag)
   );

   assign rsp_component      = out_tag.row;
   assign rsp_last_component = out_tag.last;
   assign rsp_block_end      = out_tag.fin;

   a_busy_needs_pixel: assert property (@(posedge clock) disable iff (reset)
      busy |-> pix_valid_ff)
      else $error("busy without a pixel in the sequencer");

   a_accept_restarts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pix_valid_ff && k_ff == '0))
      else $error("accepted pixel did not start at its first component");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_component <= ROW_MAX))
      else $error("result row out of range");

   a_components_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_component) |=> rsp_strobe)
      else $error("gap inside the results of one pixel");

   a_k_bounded: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff |-> (k_ff < count_eff))
      else $error("component counter past the count");

endmodule
